>>> rtl/sbpt_pkg.sv
// Shared types and constants for the servo bus packet transaction engine.
package sbpt_pkg;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_LINE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_RX      = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam int         FRAME_OVERHEAD = 6;
    localparam int         INPUT_PARAMS = 3;

    localparam logic [7:0] REPLY_TIMEOUT_RST = 8'd20;
    localparam logic [7:0] ECHO_TIMEOUT_RST  = 8'd5;

    localparam logic [0:0] REG_REPLY_TIMEOUT = 1'b0;
    localparam logic [0:0] REG_ECHO_TIMEOUT  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ECHO  = 2'd1,
        PH_REPLY = 2'd2
    } phase_t;

endpackage

>>> rtl/servo_bus_packet_transaction.sv
// Servo bus packet transaction engine: command framer, echo drop, reply collection.
// Each result passes through the batch register and then the output register.
// Throughput: one input per cycle, unless the output stalls, while each input yields
// at most one result; a send command fills the frame register and holds s_tready low
// until its 6+params bytes drain, one transfer per cycle unless m_tready stalls.
// Reset: asynchronous active-low; idle, timeouts 20 ms reply and 5 ms echo.
module servo_bus_packet_transaction #(
    parameter int MAX_PARAMS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // device_id[7:0], instruction[15:8], param_count[17:16], param_a[25:18],
    // param_b[33:26], param_c[41:34], reply_length[45:42], line_byte[53:46]
    input  logic [55:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // data_byte[7:0], byte_index[11:8], header_ok[12]
    output logic [15:0] m_tdata,
    // kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sbpt_pkg::*;

    localparam int LIM       = (MAX_PARAMS < INPUT_PARAMS) ? MAX_PARAMS : INPUT_PARAMS;
    localparam int FRAME_LEN = FRAME_OVERHEAD + LIM;

    // configuration
    logic [7:0] reply_to_reg;
    logic [7:0] echo_to_reg;
    logic       cfg_wr;

    // transaction state
    phase_t     phase_reg, phase_next;
    logic [3:0] echo_left_reg, echo_left_next;
    logic [3:0] reply_left_reg, reply_left_next;
    logic [3:0] reply_pos_reg, reply_pos_next;
    logic [7:0] elapsed_reg, elapsed_next;
    logic       hdr_ok_reg, hdr_ok_next;

    // result batch (frame bytes drained by shifting)
    logic [7:0] b_bytes_reg [FRAME_LEN];
    logic [7:0] b_bytes_next [FRAME_LEN];
    logic [3:0] b_left_reg, b_left_next;
    logic [3:0] b_idx_reg, b_idx_next;
    logic [1:0] b_kind_reg, b_kind_next;
    logic       b_tlast_reg, b_tlast_next;
    logic       b_thok_reg, b_thok_next;

    // output register
    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic [1:0]  m_user_reg;
    logic        m_last_reg;

    // input fields
    logic [1:0] opcode;
    logic [7:0] device_id, instruction, line_byte;
    logic [1:0] param_count, pc_clamp;
    logic [3:0] reply_length;
    logic [7:0] pa [4];
    logic [7:0] len_byte, csum;
    logic [7:0] frame [FRAME_LEN];

    logic out_free, emit, in_xfer;
    logic load;
    logic [1:0] ld_kind;
    logic [7:0] ld_byte;
    logic [3:0] ld_left, ld_idx;
    logic       ld_tlast, ld_thok;
    logic [3:0] rl_dec;
    logic       rx_last, hdr_ok_rx;

    assign opcode       = s_tuser;
    assign device_id    = s_tdata[7:0];
    assign instruction  = s_tdata[15:8];
    assign param_count  = s_tdata[17:16];
    assign pa[0]        = s_tdata[25:18];
    assign pa[1]        = s_tdata[33:26];
    assign pa[2]        = s_tdata[41:34];
    assign pa[3]        = 8'h00;
    assign reply_length = s_tdata[45:42];
    assign line_byte    = s_tdata[53:46];

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = (b_left_reg != 4'd0) && out_free;
    assign s_tready = (b_left_reg == 4'd0) || ((b_left_reg == 4'd1) && out_free);
    assign in_xfer  = s_tvalid && s_tready;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ECHO_TIMEOUT) ? {24'd0, echo_to_reg}
                                                   : {24'd0, reply_to_reg};

    // frame assembly
    always_comb
    begin
        logic [7:0] sum;
        pc_clamp = (param_count > 2'(LIM)) ? 2'(LIM) : param_count;
        len_byte = {6'd0, pc_clamp} + 8'd2;
        sum = device_id + len_byte + instruction;
        for (int i = 0; i < LIM; i++)
        begin
            if (i < int'(pc_clamp))
            begin
                sum = sum + pa[i];
            end
        end
        csum = ~sum;
        frame[0] = HDR_BYTE;
        frame[1] = HDR_BYTE;
        frame[2] = device_id;
        frame[3] = len_byte;
        frame[4] = instruction;
        for (int j = 5; j < FRAME_LEN; j++)
        begin
            if ((j - 5) < int'(pc_clamp))
            begin
                frame[j] = pa[j - 5];
            end
            else if ((j - 5) == int'(pc_clamp))
            begin
                frame[j] = csum;
            end
            else
            begin
                frame[j] = 8'h00;
            end
        end
    end

    // transaction control
    always_comb
    begin
        phase_next      = phase_reg;
        echo_left_next  = echo_left_reg;
        reply_left_next = reply_left_reg;
        reply_pos_next  = reply_pos_reg;
        elapsed_next    = elapsed_reg;
        hdr_ok_next     = hdr_ok_reg;
        load     = 1'b0;
        ld_kind  = KIND_TX;
        ld_byte  = 8'h00;
        ld_left  = 4'd1;
        ld_idx   = reply_pos_reg;
        ld_tlast = 1'b1;
        ld_thok  = 1'b0;
        rl_dec    = (reply_left_reg != 4'd0) ? reply_left_reg - 4'd1 : 4'd0;
        rx_last   = (rl_dec == 4'd0);
        hdr_ok_rx = hdr_ok_reg && !((reply_pos_reg < 4'd2) && (line_byte != HDR_BYTE));

        if (in_xfer)
        begin
            case (opcode)
                OP_SEND:
                begin
                    load            = 1'b1;
                    ld_kind         = KIND_TX;
                    ld_left         = 4'(FRAME_OVERHEAD) + {2'd0, pc_clamp};
                    ld_idx          = 4'd0;
                    phase_next      = PH_ECHO;
                    echo_left_next  = 4'(FRAME_OVERHEAD) + {2'd0, pc_clamp};
                    reply_left_next = reply_length;
                    reply_pos_next  = 4'd0;
                    elapsed_next    = 8'd0;
                    hdr_ok_next     = 1'b1;
                end
                OP_LINE:
                begin
                    if (phase_reg == PH_ECHO)
                    begin
                        echo_left_next = (echo_left_reg != 4'd0) ? echo_left_reg - 4'd1 : 4'd0;
                        if (echo_left_next == 4'd0)
                        begin
                            elapsed_next = 8'd0;
                            phase_next   = (reply_left_reg == 4'd0) ? PH_IDLE : PH_REPLY;
                        end
                    end
                    else if (phase_reg == PH_REPLY)
                    begin
                        load            = 1'b1;
                        ld_kind         = KIND_RX;
                        ld_byte         = line_byte;
                        ld_tlast        = rx_last;
                        ld_thok         = rx_last && hdr_ok_rx;
                        hdr_ok_next     = hdr_ok_rx;
                        reply_left_next = rl_dec;
                        reply_pos_next  = reply_pos_reg + 4'd1;
                        if (rx_last)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (phase_reg == PH_ECHO)
                    begin
                        if (elapsed_reg >= echo_to_reg)
                        begin
                            elapsed_next   = 8'd0;
                            echo_left_next = 4'd0;
                            phase_next     = (reply_left_reg == 4'd0) ? PH_IDLE : PH_REPLY;
                        end
                        else
                        begin
                            elapsed_next = elapsed_reg + 8'd1;
                        end
                    end
                    else if (phase_reg == PH_REPLY)
                    begin
                        if (elapsed_reg >= reply_to_reg)
                        begin
                            load            = 1'b1;
                            ld_kind         = KIND_TIMEOUT;
                            phase_next      = PH_IDLE;
                            reply_left_next = 4'd0;
                            elapsed_next    = 8'd0;
                        end
                        else
                        begin
                            elapsed_next = elapsed_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // batch next value
    always_comb
    begin
        b_bytes_next = b_bytes_reg;
        b_left_next  = b_left_reg;
        b_idx_next   = b_idx_reg;
        b_kind_next  = b_kind_reg;
        b_tlast_next = b_tlast_reg;
        b_thok_next  = b_thok_reg;
        if (emit)
        begin
            for (int j = 0; j < FRAME_LEN - 1; j++)
            begin
                b_bytes_next[j] = b_bytes_reg[j + 1];
            end
            b_bytes_next[FRAME_LEN - 1] = 8'h00;
            b_left_next = b_left_reg - 4'd1;
            b_idx_next  = b_idx_reg + 4'd1;
        end
        if (load)
        begin
            if (ld_kind == KIND_TX)
            begin
                b_bytes_next = frame;
            end
            else
            begin
                b_bytes_next[0] = ld_byte;
            end
            b_left_next  = ld_left;
            b_idx_next   = ld_idx;
            b_kind_next  = ld_kind;
            b_tlast_next = ld_tlast;
            b_thok_next  = ld_thok;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_to_reg   <= REPLY_TIMEOUT_RST;
            echo_to_reg    <= ECHO_TIMEOUT_RST;
            phase_reg      <= PH_IDLE;
            echo_left_reg  <= 4'd0;
            reply_left_reg <= 4'd0;
            reply_pos_reg  <= 4'd0;
            elapsed_reg    <= 8'd0;
            hdr_ok_reg     <= 1'b1;
            b_left_reg     <= 4'd0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == REG_ECHO_TIMEOUT)
                begin
                    echo_to_reg <= pwdata[7:0];
                end
                else
                begin
                    reply_to_reg <= pwdata[7:0];
                end
            end
            phase_reg      <= phase_next;
            echo_left_reg  <= echo_left_next;
            reply_left_reg <= reply_left_next;
            reply_pos_reg  <= reply_pos_next;
            elapsed_reg    <= elapsed_next;
            hdr_ok_reg     <= hdr_ok_next;
            b_left_reg     <= b_left_next;
            if (out_free)
            begin
                m_valid_reg <= emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        b_bytes_reg <= b_bytes_next;
        b_idx_reg   <= b_idx_next;
        b_kind_reg  <= b_kind_next;
        b_tlast_reg <= b_tlast_next;
        b_thok_reg  <= b_thok_next;
        if (emit)
        begin
            m_data_reg <= {3'd0, (b_left_reg == 4'd1) && b_thok_reg, b_idx_reg, b_bytes_reg[0]};
            m_user_reg <= b_kind_reg;
            m_last_reg <= (b_left_reg == 4'd1) && b_tlast_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (b_left_reg > 4'd1) |-> !s_tready)
        else $error("input accepted while batch still draining");

    a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        b_left_reg <= 4'(FRAME_LEN))
        else $error("batch count exceeds frame length");

    a_echo_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ECHO) == (echo_left_reg != 4'd0))
        else $error("echo count disagrees with phase");

    a_timeout_item: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_TIMEOUT)) |-> (m_tlast && (m_tdata[7:0] == 8'h00)))
        else $error("malformed timeout result");
`endif

endmodule

>>> tb/tb_servo_bus_packet_transaction.sv
// Self-checking testbench for the servo bus packet transaction engine.
module tb_servo_bus_packet_transaction;
    import sbpt_pkg::*;

    localparam int         TB_MAX_PARAMS = 3;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES  = 8;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [55:0] data;
    } bus_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] idx;
        logic       last;
        logic       hok;
    } bus_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    bus_item_t   cmd_backlog[$];
    bus_result_t expected_out[$];
    bus_result_t mon_got;
    bus_result_t mon_want;
    bus_item_t   drv_item;

    int   queued_cnt   = 0;
    int   accepted_cnt = 0;
    int   errors       = 0;
    int   quiet_cycles = 0;
    int   tx_idle      = 0;
    int   rx_idle      = 0;
    logic s_fire       = 1'b0;

    // predictor state and register copies
    phase_t     mdl_phase      = PH_IDLE;
    logic [3:0] mdl_echo_left  = '0;
    logic [3:0] mdl_reply_left = '0;
    logic [3:0] mdl_reply_pos  = '0;
    logic [7:0] mdl_elapsed    = '0;
    logic       mdl_hdr_ok     = 1'b1;
    logic [7:0] mdl_reply_to   = REPLY_TIMEOUT_RST;
    logic [7:0] mdl_echo_to    = ECHO_TIMEOUT_RST;

    // register values as the stimulus generator sees them
    int stim_reply_to = int'(REPLY_TIMEOUT_RST);
    int stim_echo_to  = int'(ECHO_TIMEOUT_RST);

    servo_bus_packet_transaction #(
        .MAX_PARAMS(TB_MAX_PARAMS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    function automatic logic [55:0] cmd_word(logic [7:0] id, logic [7:0] ins, logic [1:0] pc,
                                             logic [7:0] pa, logic [7:0] pb, logic [7:0] pz,
                                             logic [3:0] rl);
        return {2'b00, 8'h00, rl, pz, pb, pa, pc, ins, id};
    endfunction

    function automatic logic [55:0] random_word();
        return {2'b00, 32'($urandom), 22'($urandom)};
    endfunction

    function automatic logic [55:0] line_word(logic [7:0] b);
        logic [55:0] w;
        w = random_word();
        w[53:46] = b;
        return w;
    endfunction

    function automatic bit tick_burst_ok(int to);
        return (to <= 40) || ($urandom_range(0, 24) == 0);
    endfunction

    task automatic push_item(logic [1:0] op, logic [55:0] d);
        bus_item_t it;
        it.op   = op;
        it.data = d;
        cmd_backlog.push_back(it);
        queued_cnt++;
    endtask

    task automatic expect_byte(logic [1:0] k, logic [7:0] b, logic [3:0] i, logic l, logic h);
        bus_result_t r;
        r.kind = k;
        r.data = b;
        r.idx  = i;
        r.last = l;
        r.hok  = h;
        expected_out.push_back(r);
    endtask

    task automatic finish_echo();
        mdl_elapsed   = '0;
        mdl_echo_left = '0;
        mdl_phase     = (mdl_reply_left == 0) ? PH_IDLE : PH_REPLY;
    endtask

    task automatic predict_transfer(logic [1:0] op, logic [55:0] d);
        logic [7:0] frame [9];
        logic [7:0] sum;
        logic [7:0] b;
        logic [3:0] pos;
        logic       l;
        int         pc;
        int         total;
        case (op)
            OP_SEND:
            begin
                pc = int'(d[17:16]);
                if (pc > TB_MAX_PARAMS)
                    pc = TB_MAX_PARAMS;
                frame[0] = HDR_BYTE;
                frame[1] = HDR_BYTE;
                frame[2] = d[7:0];
                frame[3] = 8'(pc + 2);
                frame[4] = d[15:8];
                frame[5] = d[25:18];
                frame[6] = d[33:26];
                frame[7] = d[41:34];
                sum = frame[2] + frame[3] + frame[4];
                for (int i = 0; i < pc; i++)
                    sum = sum + frame[5 + i];
                frame[5 + pc] = ~sum;
                total = FRAME_OVERHEAD + pc;
                for (int i = 0; i < total; i++)
                    expect_byte(KIND_TX, frame[i], 4'(i), i == total - 1, 1'b0);
                mdl_phase      = PH_ECHO;
                mdl_echo_left  = 4'(total);
                mdl_reply_left = d[45:42];
                mdl_reply_pos  = '0;
                mdl_elapsed    = '0;
                mdl_hdr_ok     = 1'b1;
            end
            OP_LINE:
            begin
                b = d[53:46];
                if (mdl_phase == PH_ECHO)
                begin
                    if (mdl_echo_left > 0)
                        mdl_echo_left = mdl_echo_left - 4'd1;
                    if (mdl_echo_left == 0)
                        finish_echo();
                end
                else if (mdl_phase == PH_REPLY)
                begin
                    pos = mdl_reply_pos;
                    if (pos < 2 && b != HDR_BYTE)
                        mdl_hdr_ok = 1'b0;
                    if (mdl_reply_left > 0)
                        mdl_reply_left = mdl_reply_left - 4'd1;
                    l = (mdl_reply_left == 0);
                    expect_byte(KIND_RX, b, pos, l, l ? mdl_hdr_ok : 1'b0);
                    mdl_reply_pos = pos + 4'd1;
                    if (l)
                        mdl_phase = PH_IDLE;
                end
            end
            OP_TICK:
            begin
                if (mdl_phase == PH_ECHO)
                begin
                    if (mdl_elapsed >= mdl_echo_to)
                        finish_echo();
                    else
                        mdl_elapsed = mdl_elapsed + 8'd1;
                end
                else if (mdl_phase == PH_REPLY)
                begin
                    if (mdl_elapsed >= mdl_reply_to)
                    begin
                        expect_byte(KIND_TIMEOUT, 8'h00, mdl_reply_pos, 1'b1, 1'b0);
                        mdl_phase      = PH_IDLE;
                        mdl_reply_left = '0;
                        mdl_elapsed    = '0;
                    end
                    else
                    begin
                        mdl_elapsed = mdl_elapsed + 8'd1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // send, echo (sometimes broken or timed out), reply (sometimes cut short or timed out)
    task automatic gen_transaction();
        logic [1:0] pc;
        logic [3:0] rl;
        int         sel;
        int         n_echo;
        int         n_reply;
        bit         cut;
        pc  = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 9);
        rl  = (sel == 0) ? 4'd0 : (sel == 1) ? 4'd15 : 4'($urandom_range(1, 5));
        push_item(OP_SEND, cmd_word(8'($urandom), 8'($urandom), pc, 8'($urandom),
                                    8'($urandom), 8'($urandom), rl));
        if ($urandom_range(0, 9) == 0 && tick_burst_ok(stim_echo_to))
        begin
            repeat (stim_echo_to + 1)
                push_item(OP_TICK, random_word());
        end
        else
        begin
            n_echo = FRAME_OVERHEAD + int'(pc);
            if ($urandom_range(0, 9) == 0)
                n_echo = $urandom_range(0, n_echo - 1);
            for (int i = 0; i < n_echo; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_item(OP_TICK, random_word());
                push_item(OP_LINE, line_word(8'($urandom)));
            end
        end
        n_reply = int'(rl);
        cut     = ($urandom_range(0, 6) == 0);
        if (cut)
            n_reply = $urandom_range(0, int'(rl));
        for (int i = 0; i < n_reply; i++)
        begin
            if ($urandom_range(0, 14) == 0)
                push_item(OP_TICK, random_word());
            push_item(OP_LINE, line_word((i < 2 && $urandom_range(0, 4) != 0) ?
                                         HDR_BYTE : 8'($urandom)));
        end
        if (cut && $urandom_range(0, 1) == 1 && tick_burst_ok(stim_reply_to))
            repeat (stim_reply_to + 1)
                push_item(OP_TICK, random_word());
    endtask

    task automatic run_random(int budget);
        int target;
        target = queued_cnt + budget;
        while (queued_cnt < target)
        begin
            if ($urandom_range(0, 9) == 0)
                push_item(2'($urandom_range(0, 3)), random_word());
            else
                gen_transaction();
        end
    endtask

    // expects reply timeout 1, echo timeout 0
    task automatic run_directed();
        push_item(OP_UNUSED, {2'b00, {54{1'b1}}});
        push_item(OP_LINE, line_word(8'h00));
        push_item(OP_TICK, '0);
        push_item(OP_SEND, cmd_word(8'hFF, 8'hFF, 2'd3, 8'hFF, 8'hFF, 8'hFF, 4'd1));
        push_item(OP_TICK, '0);
        push_item(OP_LINE, line_word(HDR_BYTE));
        push_item(OP_SEND, cmd_word(8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00, 4'd0));
        push_item(OP_TICK, '0);
        push_item(OP_SEND, cmd_word(8'h5A, 8'hC3, 2'd2, 8'h01, 8'h80, 8'h00, 4'd15));
        push_item(OP_TICK, '0);
        push_item(OP_LINE, line_word(8'h00));
        push_item(OP_TICK, '0);
        push_item(OP_TICK, '0);
        push_item(OP_SEND, cmd_word(8'h12, 8'h03, 2'd1, 8'h2B, 8'h00, 8'h00, 4'd3));
        push_item(OP_SEND, cmd_word(8'h01, 8'h02, 2'd0, 8'h00, 8'h00, 8'h00, 4'd2));
        repeat (FRAME_OVERHEAD)
            push_item(OP_LINE, line_word(8'($urandom)));
        push_item(OP_LINE, line_word(HDR_BYTE));
        push_item(OP_LINE, line_word(8'h12));
    endtask

    task automatic wait_drained();
        while (!(accepted_cnt == queued_cnt && expected_out.size() == 0))
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [7:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REPLY_TIMEOUT: stim_reply_to = int'(val);
            REG_ECHO_TIMEOUT:  stim_echo_to  = int'(val);
            default: ;
        endcase
    endtask

    task automatic set_timeouts(logic [7:0] reply_to, logic [7:0] echo_to);
        write_reg(REG_REPLY_TIMEOUT, reply_to);
        write_reg(REG_ECHO_TIMEOUT, echo_to);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_fire)
        begin
            if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= tx_idle)
            begin
                drv_item = cmd_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_item.data;
                s_tuser  <= drv_item.op;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle);

    // monitor and scoreboard
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_fire <= 1'b0;
        end
        else
        begin
            s_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                mon_got.kind = m_tuser;
                mon_got.data = m_tdata[7:0];
                mon_got.idx  = m_tdata[11:8];
                mon_got.last = m_tlast;
                mon_got.hok  = m_tdata[12];
                if (expected_out.size() == 0)
                begin
                    $display("%0t: unexpected transfer kind=%0d data=%02h idx=%0d last=%0b hok=%0b",
                             $time, mon_got.kind, mon_got.data, mon_got.idx, mon_got.last,
                             mon_got.hok);
                    errors++;
                end
                else
                begin
                    mon_want = expected_out.pop_front();
                    if (mon_got !== mon_want)
                    begin
                        $display("%0t: expected kind=%0d data=%02h idx=%0d last=%0b hok=%0b",
                                 $time, mon_want.kind, mon_want.data, mon_want.idx,
                                 mon_want.last, mon_want.hok);
                        $display("%0t:   actual kind=%0d data=%02h idx=%0d last=%0b hok=%0b",
                                 $time, mon_got.kind, mon_got.data, mon_got.idx,
                                 mon_got.last, mon_got.hok);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_transfer(s_tuser, s_tdata);
                accepted_cnt++;
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2:2])
                    REG_REPLY_TIMEOUT: mdl_reply_to = pwdata[7:0];
                    REG_ECHO_TIMEOUT:  mdl_echo_to  = pwdata[7:0];
                    default: ;
                endcase
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tx_idle = 27;
        rx_idle = 52;
        set_timeouts(8'd1, 8'd0);
        run_directed();
        wait_drained();
        set_timeouts(REPLY_TIMEOUT_RST, ECHO_TIMEOUT_RST);
        run_random(120);
        wait_drained();
        tx_idle = 52;
        rx_idle = 27;
        set_timeouts(8'd0, 8'd0);
        run_random(120);
        wait_drained();
        set_timeouts(8'd255, 8'd255);
        run_random(120);
        wait_drained();
        tx_idle = 0;
        rx_idle = 0;
        set_timeouts(8'($urandom_range(1, 12)), 8'($urandom_range(1, 6)));
        run_random(120);
        wait_drained();
        if (expected_out.size() != 0)
        begin
            $display("%0t: %0d expected transfers never arrived", $time, expected_out.size());
            errors++;
        end
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> servo_bus_packet_transaction.f
rtl/sbpt_pkg.sv
rtl/servo_bus_packet_transaction.sv
tb/tb_servo_bus_packet_transaction.sv
